FILE: hdl/cga_pkg.sv
// ----------------------------------------------------------------------------
// cga_pkg
// Shared widths, constants and types for the central gravity acceleration
// pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package cga_pkg;

	localparam int POS_W     = 32;
	localparam int ACC_W     = 48;
	localparam int FRAC_BITS = 24;
	localparam int MU_W      = 48;

	localparam int MU_LO_W    = MU_W / 2;
	localparam int MU_HI_W    = MU_W - MU_LO_W;
	localparam int SQ_W       = 2 * POS_W;
	localparam int ROOT_W     = POS_W;
	localparam int SQRT_STEPS = SQ_W / 2;
	localparam int REM_W      = ROOT_W + 2;
	localparam int R2_W       = 2 * ROOT_W;
	localparam int DEN_W      = 3 * ROOT_W;
	localparam int D2_W       = DEN_W + 1;
	localparam int PROD_W     = MU_W + POS_W;
	localparam int NUM_W      = PROD_W + FRAC_BITS + 2;
	localparam int QUO_W      = ACC_W;
	localparam int HEAD_W     = NUM_W - QUO_W;

	localparam logic [ACC_W-1:0] ACC_POS_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic [ACC_W-1:0] ACC_NEG_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	// carried alongside the root pipeline
	typedef struct packed {
		logic                   zero;
		logic [2:0]             neg;
		logic [2:0][POS_W-1:0]  mag;
	} sq_side_t;

	// carried alongside the divider
	typedef struct packed {
		logic       zero;
		logic [2:0] neg;
	} dv_side_t;

	typedef struct packed {
		logic [2:0][ACC_W-1:0] accel;
		logic                  clipped;
		logic                  at_centre;
	} result_t;

endpackage

`default_nettype wire

FILE: hdl/central_gravity_acceleration.sv
// ----------------------------------------------------------------------------
// central_gravity_acceleration
// Point-mass gravity: a = -mu * p / r^3 with r the rounded integer root of
// |p|^2, fixed-point output with saturation and a zero-position flag.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  input     in_valid / in_ready    pos_x, pos_y, pos_z
//  output    out_valid / out_ready  accel_x, accel_y, accel_z, clipped, at_centre
//  config    cfg_we                 cfg_wdata (grav_param)
//
//  One request per cycle sustained while the result queue is not full.
//  Most of the pipeline depth is in the 32 root-bit stages and the 48 quotient-bit stages.
//  Reset clears all valid bits, the result queue and grav_param.
//  The pipeline stalls as a whole only when the two-entry result queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module central_gravity_acceleration import cga_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [MU_W-1:0]         cfg_wdata,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [POS_W-1:0] pos_x,
	input  logic signed [POS_W-1:0] pos_y,
	input  logic signed [POS_W-1:0] pos_z,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [ACC_W-1:0] accel_x,
	output logic signed [ACC_W-1:0] accel_y,
	output logic signed [ACC_W-1:0] accel_z,
	output logic                    clipped,
	output logic                    at_centre
);

	logic            grav_param_q;
	logic [MU_W-1:0] mu_q;
	logic            en;
	logic            full;

	logic [2:0][POS_W-1:0] pos_c;

	logic                  vld_s1;
	logic [2:0][POS_W-1:0] mag_s1;
	logic [2:0]            neg_s1;

	logic                  vld_s2;
	logic [2:0][SQ_W-1:0]  sq_s2;
	sq_side_t              side_s2;

	logic                  vld_s3;
	logic [SQ_W-1:0]       sum_s3;
	sq_side_t              side_s3;

	logic                  rt_valid;
	logic [ROOT_W-1:0]     rt_root;
	sq_side_t              rt_side;

	logic                          vld_s4;
	logic [ROOT_W-1:0]             r_s4;
	logic [R2_W-1:0]               r2_s4;
	logic [2:0][MU_LO_W+POS_W-1:0] pml_s4;
	logic [2:0][MU_HI_W+POS_W-1:0] pmh_s4;
	dv_side_t                      dside_s4;

	logic                   vld_s5;
	logic [R2_W-1:0]        dlo_s5;
	logic [R2_W-1:0]        dhi_s5;
	logic [2:0][PROD_W-1:0] prod_s5;
	dv_side_t               dside_s5;

	logic                   vld_s6;
	logic [DEN_W-1:0]       den_s6;
	logic [2:0][PROD_W-1:0] prod_s6;
	dv_side_t               dside_s6;

	logic                   vld_s7;
	logic [2:0][NUM_W-1:0]  num_s7;
	logic [D2_W-1:0]        d2_s7;
	dv_side_t               dside_s7;

	logic                   dv_valid;
	logic [2:0][QUO_W-1:0]  dv_quo;
	logic [2:0]             dv_ovf;
	dv_side_t               dv_side;

	logic                   vld_s8;
	result_t                res_s8;
	result_t                res_c;
	result_t                res_out;

	logic [2:0][ACC_W-1:0]  lim_c;
	logic [2:0][ACC_W-1:0]  val_c;
	logic [2:0]             over_c;

	assign grav_param_q = |mu_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mu_q <= '0;
		end else if (cfg_we) begin
			mu_q <= cfg_wdata;
		end
	end

	assign en       = !full;
	assign in_ready = en;
	assign pos_c    = {pos_z, pos_y, pos_x};

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= rt_valid;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= dv_valid;
		end
	end

	// magnitudes, squares, sum of squares
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				neg_s1[j] <= pos_c[j][POS_W-1];
				mag_s1[j] <= pos_c[j][POS_W-1] ? (~pos_c[j] + 1'b1) : pos_c[j];
				sq_s2[j]  <= mag_s1[j] * mag_s1[j];
			end
			side_s2.mag  <= mag_s1;
			side_s2.neg  <= neg_s1;
			side_s2.zero <= ~|mag_s1;
			sum_s3       <= sq_s2[0] + sq_s2[1] + sq_s2[2];
			side_s3      <= side_s2;
		end
	end

	cga_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s3),
		.rad       (sum_s3),
		.in_side   (side_s3),
		.out_valid (rt_valid),
		.root      (rt_root),
		.out_side  (rt_side)
	);

	// r^3 in split products; mu * |p_i| in split products
	always_ff @(posedge clk) begin
		if (en) begin
			r_s4  <= rt_root;
			r2_s4 <= rt_root * rt_root;
			for (int j = 0; j < 3; j++) begin
				pml_s4[j] <= mu_q[MU_LO_W-1:0] * rt_side.mag[j];
				pmh_s4[j] <= mu_q[MU_W-1:MU_LO_W] * rt_side.mag[j];
			end
			dside_s4.neg  <= rt_side.neg;
			dside_s4.zero <= rt_side.zero;

			dlo_s5 <= r2_s4[ROOT_W-1:0] * r_s4;
			dhi_s5 <= r2_s4[R2_W-1:ROOT_W] * r_s4;
			for (int j = 0; j < 3; j++) begin
				prod_s5[j] <= (PROD_W'(pmh_s4[j]) << MU_LO_W) + PROD_W'(pml_s4[j]);
			end
			dside_s5 <= dside_s4;

			den_s6   <= (DEN_W'(dhi_s5) << ROOT_W) + DEN_W'(dlo_s5);
			prod_s6  <= prod_s5;
			dside_s6 <= dside_s5;

			// dividend carries the half-divisor rounding bias
			for (int j = 0; j < 3; j++) begin
				num_s7[j] <= (NUM_W'(prod_s6[j]) << (FRAC_BITS + 1)) + NUM_W'(den_s6);
			end
			d2_s7    <= {den_s6, 1'b0};
			dside_s7 <= dside_s6;
		end
	end

	cga_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s7),
		.num       (num_s7),
		.d2        (d2_s7),
		.in_side   (dside_s7),
		.out_valid (dv_valid),
		.quo       (dv_quo),
		.ovf       (dv_ovf),
		.out_side  (dv_side)
	);

	// saturate and apply sign opposite to the position
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			lim_c[j]  = dv_side.neg[j] ? ACC_POS_MAX : ACC_NEG_MIN;
			over_c[j] = dv_ovf[j] || (dv_quo[j] > lim_c[j]);
			val_c[j]  = over_c[j] ? lim_c[j] : dv_quo[j];
			res_c.accel[j] = dv_side.zero ? '0
				: (dv_side.neg[j] ? val_c[j] : (~val_c[j] + 1'b1));
		end
		res_c.clipped   = !dv_side.zero && (|over_c) && grav_param_q;
		res_c.at_centre = dv_side.zero;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s8 <= res_c;
		end
	end

	cga_ofifo u_ofifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (en && vld_s8),
		.din       (res_s8),
		.full      (full),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.dout      (res_out)
	);

	assign accel_x   = res_out.accel[0];
	assign accel_y   = res_out.accel[1];
	assign accel_z   = res_out.accel[2];
	assign clipped   = res_out.clipped;
	assign at_centre = res_out.at_centre;

endmodule

`default_nettype wire

FILE: hdl/cga_isqrt.sv
// ----------------------------------------------------------------------------
// cga_isqrt
// Pipelined digit-by-digit square root, one root bit per stage, followed by
// a round-to-nearest stage.
// ----------------------------------------------------------------------------
`default_nettype none

module cga_isqrt import cga_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [SQ_W-1:0]   rad,
	input  sq_side_t          in_side,
	output logic              out_valid,
	output logic [ROOT_W-1:0] root,
	output sq_side_t          out_side
);

	logic              vld_s  [SQRT_STEPS+1];
	logic [SQ_W-1:0]   rad_s  [SQRT_STEPS+1];
	logic [REM_W-1:0]  rem_s  [SQRT_STEPS+1];
	logic [ROOT_W-1:0] root_s [SQRT_STEPS+1];
	sq_side_t          side_s [SQRT_STEPS+1];

	logic              rnd_vld_s;
	logic [ROOT_W-1:0] rnd_root_s;
	sq_side_t          rnd_side_s;

	assign vld_s[0]  = in_valid;
	assign rad_s[0]  = rad;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign side_s[0] = in_side;

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
		logic [REM_W+1:0] rem_n;
		logic [REM_W+1:0] trial;
		logic [REM_W+1:0] diff;
		logic             ge;

		always_comb begin
			rem_n = {rem_s[k], rad_s[k][SQ_W-1 -: 2]};
			trial = {2'b00, root_s[k], 2'b01};
			ge    = rem_n >= trial;
			diff  = rem_n - trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k+1]  <= rad_s[k] << 2;
				rem_s[k+1]  <= ge ? diff[REM_W-1:0] : rem_n[REM_W-1:0];
				root_s[k+1] <= {root_s[k][ROOT_W-2:0], ge};
				side_s[k+1] <= side_s[k];
			end
		end
	end

	// remainder above the root means the upper neighbor is nearer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rnd_vld_s <= 1'b0;
		end else if (en) begin
			rnd_vld_s <= vld_s[SQRT_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rnd_root_s <= root_s[SQRT_STEPS]
				+ ROOT_W'(rem_s[SQRT_STEPS] > {2'b00, root_s[SQRT_STEPS]});
			rnd_side_s <= side_s[SQRT_STEPS];
		end
	end

	assign out_valid = rnd_vld_s;
	assign root      = rnd_root_s;
	assign out_side  = rnd_side_s;

endmodule

`default_nettype wire

FILE: hdl/cga_div.sv
// ----------------------------------------------------------------------------
// cga_div
// Three-lane pipelined restoring divider with a shared divisor: an overflow
// check stage, then one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module cga_div import cga_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  logic [2:0][NUM_W-1:0]  num,
	input  logic [D2_W-1:0]        d2,
	input  dv_side_t               in_side,
	output logic                   out_valid,
	output logic [2:0][QUO_W-1:0]  quo,
	output logic [2:0]             ovf,
	output dv_side_t               out_side
);

	logic                  vld_s  [QUO_W+1];
	logic [2:0][D2_W-1:0]  rem_s  [QUO_W+1];
	// low dividend bits shift out the top while quotient bits enter below
	logic [2:0][QUO_W-1:0] lq_s   [QUO_W+1];
	logic [D2_W-1:0]       d2_s   [QUO_W+1];
	logic [2:0]            ovf_s  [QUO_W+1];
	dv_side_t              side_s [QUO_W+1];

	logic [2:0][D2_W:0]    head_c;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			head_c[j] = {{(D2_W+1-HEAD_W){1'b0}}, num[j][NUM_W-1:QUO_W]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				ovf_s[0][j] <= head_c[j] >= {1'b0, d2};
				rem_s[0][j] <= head_c[j][D2_W-1:0];
				lq_s[0][j]  <= num[j][QUO_W-1:0];
			end
			d2_s[0]   <= d2;
			side_s[0] <= in_side;
		end
	end

	for (genvar k = 0; k < QUO_W; k++) begin : g_step
		logic [2:0][D2_W:0] rem_n;
		logic [2:0][D2_W:0] diff;
		logic [2:0]         ge;

		always_comb begin
			for (int j = 0; j < 3; j++) begin
				rem_n[j] = {rem_s[k][j], lq_s[k][j][QUO_W-1]};
				ge[j]    = rem_n[j] >= {1'b0, d2_s[k]};
				diff[j]  = rem_n[j] - {1'b0, d2_s[k]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int j = 0; j < 3; j++) begin
					rem_s[k+1][j] <= ge[j] ? diff[j][D2_W-1:0] : rem_n[j][D2_W-1:0];
					lq_s[k+1][j]  <= {lq_s[k][j][QUO_W-2:0], ge[j]};
				end
				d2_s[k+1]   <= d2_s[k];
				ovf_s[k+1]  <= ovf_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = vld_s[QUO_W];
	assign quo       = lq_s[QUO_W];
	assign ovf       = ovf_s[QUO_W];
	assign out_side  = side_s[QUO_W];

endmodule

`default_nettype wire

FILE: hdl/cga_ofifo.sv
// ----------------------------------------------------------------------------
// cga_ofifo
// Two-entry result queue; decouples the pipeline stall from out_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module cga_ofifo import cga_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t din,
	output logic    full,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t dout
);

	logic [1:0] cnt_q;
	logic [1:0] cnt_d;
	result_t    ent0_q;
	result_t    ent1_q;
	logic       pop;

	assign pop       = out_valid && out_ready;
	assign out_valid = cnt_q != 2'd0;
	assign full      = cnt_q == 2'd2;
	assign dout      = ent0_q;

	always_comb begin
		unique case ({push, pop})
			2'b10:   cnt_d = cnt_q + 2'd1;
			2'b01:   cnt_d = cnt_q - 2'd1;
			default: cnt_d = cnt_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case ({push, pop})
			2'b10: begin
				if (cnt_q == 2'd0) begin
					ent0_q <= din;
				end else begin
					ent1_q <= din;
				end
			end
			2'b01: begin
				ent0_q <= ent1_q;
			end
			2'b11: begin
				if (cnt_q == 2'd1) begin
					ent0_q <= din;
				end else begin
					ent0_q <= ent1_q;
					ent1_q <= din;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: hdl/cga_checker.sv
// ----------------------------------------------------------------------------
// cga_checker
// Port-level checks for central_gravity_acceleration, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cga_checker import cga_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic signed [ACC_W-1:0] accel_x,
	input logic signed [ACC_W-1:0] accel_y,
	input logic signed [ACC_W-1:0] accel_z,
	input logic                    clipped,
	input logic                    at_centre
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(accel_x) && $stable(accel_y)
			&& $stable(accel_z) && $stable(clipped) && $stable(at_centre))
		else $error("result changed while stalled");

	a_centre: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && at_centre |-> accel_x == '0 && accel_y == '0 && accel_z == '0
			&& !clipped)
		else $error("zero position gave nonzero result");

	a_clip: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && clipped |->
			accel_x == ACC_POS_MAX || accel_x == ACC_NEG_MIN
			|| accel_y == ACC_POS_MAX || accel_y == ACC_NEG_MIN
			|| accel_z == ACC_POS_MAX || accel_z == ACC_NEG_MIN)
		else $error("clip flag without a saturated component");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no result pending");

	a_reset: assert property (@(posedge clk) $rose(arst_n) |-> !out_valid)
		else $error("result valid out of reset");

endmodule

bind central_gravity_acceleration cga_checker u_cga_checker (.*);

`default_nettype wire

FILE: test/tb_central_gravity_acceleration.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_central_gravity_acceleration
// Sends position requests through the gravity pipeline under several idle and
// back-pressure patterns and mu settings. Each result is checked against an
// exact wide-integer predictor or a typed expected value.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_central_gravity_acceleration;
	import cga_pkg::*;

	typedef struct {
		logic [2:0][ACC_W-1:0] accel;
		logic                  clipped;
		logic                  at_centre;
	} accel_res_t;

	typedef struct {
		logic [MU_W-1:0]         mu;
		logic signed [POS_W-1:0] x, y, z;
		bit                      typed;
		accel_res_t              res;
	} vec_row_t;

	localparam logic [MU_W-1:0] MU_MAX = {MU_W{1'b1}};
	localparam logic signed [POS_W-1:0] P_MAX = {1'b0, {(POS_W-1){1'b1}}};
	localparam logic signed [POS_W-1:0] P_MIN = {1'b1, {(POS_W-1){1'b0}}};

	logic clk, arst_n, cfg_we, in_valid, in_ready, out_valid, out_ready;
	logic [MU_W-1:0] cfg_wdata;
	logic signed [POS_W-1:0] pos_x, pos_y, pos_z;
	logic signed [ACC_W-1:0] accel_x, accel_y, accel_z;
	logic clipped, at_centre;

	central_gravity_acceleration DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z),
		.clipped(clipped), .at_centre(at_centre)
	);

	logic [MU_W-1:0] mu_now;
	accel_res_t      accel_due[$];
	int              errors;
	int              snd_idle, rcv_stall;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("central_gravity_acceleration: mismatch");
		$finish;
	end

	function automatic accel_res_t gravity_of(logic [MU_W-1:0] mu,
			logic signed [POS_W-1:0] px, logic signed [POS_W-1:0] py,
			logic signed [POS_W-1:0] pz);
		accel_res_t r;
		logic signed [POS_W-1:0] p[3];
		logic [POS_W-1:0] mag[3];
		logic [191:0] s, root, c, rem, den, num, q, lim;
		p[0] = px; p[1] = py; p[2] = pz;
		s = '0;
		r.clipped = 1'b0;
		r.at_centre = 1'b0;
		r.accel = '0;
		for (int i = 0; i < 3; i++) begin
			mag[i] = p[i][POS_W-1] ? (~p[i] + 1'b1) : p[i];
			s += 192'(mag[i]) * 192'(mag[i]);
		end
		if (s == 0) begin
			r.at_centre = 1'b1;
			return r;
		end
		root = '0;
		for (int b = 34; b >= 0; b--) begin
			c = root | (192'(1) << b);
			if (c * c <= s)
				root = c;
		end
		rem = s - root * root;
		if (rem > root)
			root += 1;
		den = root * root * root;
		for (int i = 0; i < 3; i++) begin
			num = ((192'(mu) * 192'(mag[i])) << (FRAC_BITS + 1)) + den;
			q = num / (den << 1);
			// result points away from the position sign
			lim = p[i][POS_W-1] ? 192'(ACC_POS_MAX) : 192'(ACC_NEG_MIN);
			if (q > lim) begin
				q = lim;
				r.clipped = 1'b1;
			end
			r.accel[i] = p[i][POS_W-1] ? q[ACC_W-1:0] : -q[ACC_W-1:0];
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [ACC_W-1:0] got,
			logic [ACC_W-1:0] want);
		$display("%0t: %s got %h want %h", $realtime, what, got, want);
		errors++;
	endtask

	// result side: stall at random, check each accepted result
	always @(posedge clk) begin
		accel_res_t w;
		if (arst_n && out_valid && out_ready) begin
			if (accel_due.size() == 0) begin
				report_mismatch("unexpected result", accel_x, '0);
			end else begin
				w = accel_due.pop_front();
				if (accel_x !== w.accel[0]) report_mismatch("accel_x", accel_x, w.accel[0]);
				if (accel_y !== w.accel[1]) report_mismatch("accel_y", accel_y, w.accel[1]);
				if (accel_z !== w.accel[2]) report_mismatch("accel_z", accel_z, w.accel[2]);
				if (clipped !== w.clipped)
					report_mismatch("clipped", 48'(clipped), 48'(w.clipped));
				if (at_centre !== w.at_centre)
					report_mismatch("at_centre", 48'(at_centre), 48'(w.at_centre));
			end
		end
		out_ready <= ($urandom_range(99) >= rcv_stall);
	end

	task automatic drain();
		while (accel_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_mu(logic [MU_W-1:0] v);
		in_valid <= 1'b0;
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		mu_now = v;
	endtask

	// one request; returns on the edge that accepts it, or after a random idle gap
	task automatic send_pos(logic signed [POS_W-1:0] x, logic signed [POS_W-1:0] y,
			logic signed [POS_W-1:0] z, bit typed, accel_res_t known);
		int gap;
		in_valid <= 1'b1;
		pos_x <= x;
		pos_y <= y;
		pos_z <= z;
		do @(posedge clk); while (!in_ready);
		accel_due.push_back(typed ? known : gravity_of(mu_now, x, y, z));
		if ($urandom_range(99) < snd_idle) begin
			gap = $urandom_range(1, 12);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic signed [POS_W-1:0] rand_pos();
		case ($urandom_range(5))
			0: return '0;
			1: return $urandom_range(1) ? P_MAX : P_MIN;
			2: return $signed(POS_W'($urandom)) >>> $urandom_range(31);
			default: return $signed(POS_W'($urandom)) >>> $urandom_range(16, 31);
		endcase
	endfunction

	function automatic accel_res_t typed_res(logic [ACC_W-1:0] ax, logic [ACC_W-1:0] ay,
			logic [ACC_W-1:0] az, logic clp, logic ctr);
		accel_res_t r;
		r.accel[0] = ax; r.accel[1] = ay; r.accel[2] = az;
		r.clipped = clp;
		r.at_centre = ctr;
		return r;
	endfunction

	initial begin
		vec_row_t rows[$];
		accel_res_t none;
		logic [MU_W-1:0] phase_mu[4];
		errors = 0;
		snd_idle = 0;
		rcv_stall = 0;
		mu_now = '0;
		none = typed_res('0, '0, '0, 1'b0, 1'b0);
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		pos_x = '0; pos_y = '0; pos_z = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// mu is zero out of reset
		rows.push_back('{'0, 0, 0, 0, 1, typed_res('0, '0, '0, 1'b0, 1'b1)});
		rows.push_back('{'0, P_MAX, P_MIN, 5, 1, typed_res('0, '0, '0, 1'b0, 1'b0)});
		rows.push_back('{'0, P_MIN, P_MIN, P_MIN, 1, typed_res('0, '0, '0, 1'b0, 1'b0)});
		// largest mu at unit distance saturates
		rows.push_back('{MU_MAX, 1, 0, 0, 1, typed_res(ACC_NEG_MIN, '0, '0, 1'b1, 1'b0)});
		rows.push_back('{MU_MAX, -1, 0, 0, 1, typed_res(ACC_POS_MAX, '0, '0, 1'b1, 1'b0)});
		rows.push_back('{MU_MAX, 0, 0, 0, 1, typed_res('0, '0, '0, 1'b0, 1'b1)});
		rows.push_back('{MU_MAX, 0, 1, -1, 0, none});
		rows.push_back('{MU_MAX, P_MAX, P_MAX, P_MAX, 0, none});
		rows.push_back('{MU_MAX, P_MIN, P_MIN, P_MIN, 0, none});
		rows.push_back('{MU_MAX, P_MIN, 0, 0, 0, none});
		rows.push_back('{MU_MAX, 0, 0, P_MAX, 0, none});
		rows.push_back('{MU_MAX, 3, 4, 12, 0, none});
		rows.push_back('{MU_MAX, -1000, 2000, -3000, 0, none});
		rows.push_back('{48'd1, 1, 0, 0, 0, none});
		rows.push_back('{48'd1, 2, 2, 1, 0, none});
		rows.push_back('{48'd1, P_MAX, 0, 0, 0, none});
		rows.push_back('{48'd398600, 6378, 0, 0, 0, none});
		rows.push_back('{48'd398600, -4000, 4000, 2000, 0, none});

		foreach (rows[i]) begin
			if (rows[i].mu != mu_now)
				write_mu(rows[i].mu);
			send_pos(rows[i].x, rows[i].y, rows[i].z, rows[i].typed, rows[i].res);
		end
		in_valid <= 1'b0;

		phase_mu[0] = MU_MAX;
		phase_mu[1] = 48'd398600441;
		phase_mu[2] = MU_W'({$urandom, $urandom});
		phase_mu[3] = 48'd1;
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin snd_idle = 0;  rcv_stall = 0;  end
				1: begin snd_idle = 87; rcv_stall = 0;  end
				2: begin snd_idle = 0;  rcv_stall = 87; end
				default: begin snd_idle = 37; rcv_stall = 37; end
			endcase
			write_mu(phase_mu[ph]);
			for (int n = 0; n < 258; n++)
				send_pos(rand_pos(), rand_pos(), rand_pos(), 1'b0, none);
			in_valid <= 1'b0;
		end

		drain();
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("central_gravity_acceleration: match");
		else
			$display("central_gravity_acceleration: mismatch");
		$finish;
	end

endmodule

`default_nettype wire
